// ----- rtl/vertex_transform_cull_defines.svh -----
// ---------------------------------------------------------------------------
// Vertex transform and cull assertion macros
// Shared assertion helpers for the vertex transform and cull block.
// ---------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_CULL_DEFINES_SVH
`define VERTEX_TRANSFORM_CULL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define VTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define VTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VTC_ASSERT_IMP(lbl, ante, cons, msg)
`define VTC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/vtc_pkg.sv -----
// ---------------------------------------------------------------------------
// Vertex transform and cull package
// Widths, register indexes, reset values and the saturation helper.
// ---------------------------------------------------------------------------
`default_nettype none

package vtc_pkg;

  localparam int COORD_W = 32;
  localparam int TEX_W   = 16;
  localparam int LANE_W  = 16;
  localparam int ROW_W   = 4 * LANE_W;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 52;
  localparam int FRAC_SH = 12;
  localparam int CLIP_W  = ACC_W - FRAC_SH;
  localparam int DVD_W   = CLIP_W + 16;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_W = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_H = 3'd5;

  localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

  // 1.0 in Q16.16.
  localparam logic [MUL_W-1:0] ONE_Q16 = 34'd65536;

  // Apply a sign to a magnitude and clamp to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] sat_mag(input logic neg,
                                                 input logic [DVD_W-1:0] mag);
    logic [COORD_W-1:0] res;
    if (neg) begin
      if (mag > DVD_W'(64'h8000_0000)) res = 32'h8000_0000;
      else res = ~mag[COORD_W-1:0] + 32'd1;
    end else begin
      if (mag > DVD_W'(64'h7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = mag[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vtc_mul.sv -----
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, used for every product.
// ---------------------------------------------------------------------------
`default_nettype none

module vtc_mul (
  input  wire logic                                clk,
  input  wire logic signed [vtc_pkg::MUL_W-1:0]    a,
  input  wire logic signed [vtc_pkg::MUL_W-1:0]    b,
  output logic      signed [vtc_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

// ----- rtl/vtc_div.sv -----
// ---------------------------------------------------------------------------
// Iterative divider
// Computes (num * 2^16) / den truncated toward zero, one bit per cycle,
// and saturates the quotient to the signed 32-bit range.
// ---------------------------------------------------------------------------
`default_nettype none

module vtc_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [vtc_pkg::CLIP_W-1:0]    num,
  input  wire logic signed [vtc_pkg::CLIP_W-1:0]    den,
  output logic                                      done_r,
  output logic             [vtc_pkg::COORD_W-1:0]   quo
);

  localparam int CW = vtc_pkg::CLIP_W;
  localparam int DW = vtc_pkg::DVD_W;

  logic [DW-1:0]               dvd_r, dvd_nxt;
  logic [CW-1:0]               dsr_r, rem_r, rem_nxt;
  logic [vtc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt, done_nxt, neg_r, neg_nxt;
  logic [CW-1:0]               num_mag, den_mag;
  logic [CW:0]                 rem_sh, diff;
  logic                        ge;

  assign num_mag = num[CW-1] ? (~num + CW'(1)) : num;
  assign den_mag = den[CW-1] ? (~den + CW'(1)) : den;
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign diff    = rem_sh - {1'b0, dsr_r};
  assign ge      = rem_sh >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num_mag, 16'h0000};
      rem_nxt  = '0;
      cnt_nxt  = vtc_pkg::CNT_W'(DW);
      neg_nxt  = num[CW-1] ^ den[CW-1];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Quotient bits shift into the bottom of the dividend register.
      rem_nxt = ge ? diff[CW-1:0] : rem_sh[CW-1:0];
      dvd_nxt = {dvd_r[DW-2:0], ge};
      cnt_nxt = cnt_r - vtc_pkg::CNT_W'(1);
      if (cnt_r == vtc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    dsr_r <= start ? den_mag : dsr_r;
  end

  assign quo = vtc_pkg::sat_mag(neg_r, dvd_r);

endmodule

`default_nettype wire

// ----- rtl/vertex_transform_cull.sv -----
// ---------------------------------------------------------------------------
// Vertex transform and backface cull
// Transforms vertices by a 4x4 matrix, divides by w, culls back faces and
// triangles with a zero w, and maps the survivors to viewport coordinates.
// ---------------------------------------------------------------------------
// A vertex holds the input stalled from acceptance until it is done: sixteen
// multiply-accumulates, three divisions by w, then a store. A zero-w vertex
// skips the divisions. A third vertex that is not dropped for zero w adds the
// cull test and, for a front face, the three result items plus any consumer stall.
// Throughput: one vertex in work at a time. Reset (rst_n low, synchronous)
// restores the identity matrix, a zero viewport scale and a new triangle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vertex_transform_cull_defines.svh"

module vertex_transform_cull #(
  parameter int COEF_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port.
  input  wire logic                                cfg_wr_en,
  input  wire logic [vtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vtc_pkg::ROW_W-1:0]           cfg_wdata,
  // Vertex input channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [vtc_pkg::COORD_W-1:0]  in_vert_x,
  input  wire logic signed [vtc_pkg::COORD_W-1:0]  in_vert_y,
  input  wire logic signed [vtc_pkg::COORD_W-1:0]  in_vert_z,
  input  wire logic [vtc_pkg::TEX_W-1:0]           in_tex_u,
  input  wire logic [vtc_pkg::TEX_W-1:0]           in_tex_v,
  // Screen vertex output channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [vtc_pkg::COORD_W-1:0]       out_screen_x,
  output logic signed [vtc_pkg::COORD_W-1:0]       out_screen_y,
  output logic signed [vtc_pkg::COORD_W-1:0]       out_ndc_depth,
  output logic [vtc_pkg::TEX_W-1:0]                out_out_u,
  output logic [vtc_pkg::TEX_W-1:0]                out_out_v,
  output logic [1:0]                               out_corner,
  output logic                                     out_last_of_triangle
);

  localparam int CW     = vtc_pkg::COORD_W;
  localparam int MW     = vtc_pkg::MUL_W;
  localparam int LW     = vtc_pkg::LANE_W;
  localparam int COEF_SH = LW - COEF_BITS;

  // The sequencer walks one vertex through transform, divide, store, and on
  // the third corner through the cull test and the three result items.
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_MUL    = 13'b0000000000010,
    S_ACC    = 13'b0000000000100,
    S_DSTART = 13'b0000000001000,
    S_DWAIT  = 13'b0000000010000,
    S_STORE  = 13'b0000000100000,
    S_CUL1   = 13'b0000001000000,
    S_CUL2   = 13'b0000010000000,
    S_CUL3   = 13'b0000100000000,
    S_VPX    = 13'b0001000000000,
    S_VPY    = 13'b0010000000000,
    S_VPO    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [vtc_pkg::ROW_W-1:0] row_r [4];
  logic [CW-1:0]             half_w_r, half_h_r;

  // Current vertex.
  logic signed [CW-1:0]      vx_r, vy_r, vz_r;
  logic [vtc_pkg::TEX_W-1:0] vu_r, vv_r;

  // Transform and divide state.
  logic [1:0]                      mrow_r, mrow_nxt, lane_r, lane_nxt;
  logic signed [vtc_pkg::ACC_W-1:0] acc_r, acc_nxt, acc_sum;
  logic signed [vtc_pkg::CLIP_W-1:0] clip_r [3];
  logic signed [vtc_pkg::CLIP_W-1:0] w_r;
  logic                            wz_r, wz_nxt;
  logic [1:0]                      drow_r, drow_nxt;
  logic signed [CW-1:0]            ndc_r [3];

  // Held corners of the current triangle.
  logic signed [CW-1:0]      held_x_r [2], held_y_r [2], held_z_r [2];
  logic [vtc_pkg::TEX_W-1:0] held_u_r [2], held_v_r [2];
  logic                      held_wz_r, held_wz_nxt;
  logic [1:0]                count_r, count_nxt;

  // Cull and emission.
  logic signed [vtc_pkg::PROD_W-1:0] pcross_r, dcross;
  logic [1:0]                        idx_r, idx_nxt;

  // Shared units.
  logic signed [MW-1:0]              mul_a, mul_b;
  logic signed [vtc_pkg::PROD_W-1:0] prod;
  logic                              div_start, div_done;
  logic [CW-1:0]                     div_quo;

  vtc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  vtc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (clip_r[drow_r]),
    .den    (w_r),
    .done_r (div_done),
    .quo    (div_quo)
  );

  // Coefficient: low COEF_BITS of the lane, sign extended, 12 fraction bits.
  function automatic logic signed [MW-1:0] coef_of(input logic [LW-1:0] lane);
    logic signed [LW-1:0] t;
    t = lane << COEF_SH;
    t = t >>> COEF_SH;
    return MW'(t);
  endfunction

  logic [LW-1:0]        lane_bits;
  logic signed [MW-1:0] coord_op;

  assign lane_bits = row_r[mrow_r][16*lane_r +: 16];

  always_comb begin
    unique case (lane_r)
      2'd0:    coord_op = MW'(vx_r);
      2'd1:    coord_op = MW'(vy_r);
      2'd2:    coord_op = MW'(vz_r);
      default: coord_op = vtc_pkg::ONE_Q16;
    endcase
  end

  // Edge vectors for the cull test, from two held corners and the current one.
  logic signed [CW:0] ax, ay, bx, by;
  always_comb begin
    ax = {held_x_r[1][CW-1], held_x_r[1]} - {held_x_r[0][CW-1], held_x_r[0]};
    ay = {held_y_r[1][CW-1], held_y_r[1]} - {held_y_r[0][CW-1], held_y_r[0]};
    bx = {ndc_r[0][CW-1], ndc_r[0]} - {held_x_r[1][CW-1], held_x_r[1]};
    by = {ndc_r[1][CW-1], ndc_r[1]} - {held_y_r[1][CW-1], held_y_r[1]};
  end

  // Emission corner values and the (v + 1.0) viewport operands.
  logic signed [CW-1:0] cx, cy, cz;
  logic [vtc_pkg::TEX_W-1:0] cu, cv;
  logic signed [CW:0]   sx, sy;
  logic [CW:0]          sx_mag, sy_mag;
  logic                 vp_neg;
  logic [CW-1:0]        vp_res;

  always_comb begin
    if (idx_r == 2'd2) begin
      cx = ndc_r[0];
      cy = ndc_r[1];
      cz = ndc_r[2];
      cu = vu_r;
      cv = vv_r;
    end else begin
      cx = held_x_r[idx_r[0]];
      cy = held_y_r[idx_r[0]];
      cz = held_z_r[idx_r[0]];
      cu = held_u_r[idx_r[0]];
      cv = held_v_r[idx_r[0]];
    end
    sx     = {cx[CW-1], cx} + (CW+1)'(65536);
    sy     = {cy[CW-1], cy} + (CW+1)'(65536);
    sx_mag = sx[CW] ? (~sx + (CW+1)'(1)) : sx;
    sy_mag = sy[CW] ? (~sy + (CW+1)'(1)) : sy;
    // The product in hand is x's in S_VPY and y's in S_VPO.
    vp_neg = (state_r == S_VPY) ? sx[CW] : sy[CW];
    vp_res = vtc_pkg::sat_mag(vp_neg,
                              vtc_pkg::DVD_W'(prod[16 +: (2*CW+1-16)]));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL: begin
        mul_a = coef_of(lane_bits);
        mul_b = coord_op;
      end
      S_CUL1: begin
        mul_a = MW'(ax);
        mul_b = MW'(by);
      end
      S_CUL2: begin
        mul_a = MW'(ay);
        mul_b = MW'(bx);
      end
      S_VPX: begin
        mul_a = MW'(sx_mag);
        mul_b = MW'(half_w_r);
      end
      S_VPY: begin
        mul_a = MW'(sy_mag);
        mul_b = MW'(half_h_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign acc_sum   = acc_r + prod[vtc_pkg::ACC_W-1:0];
  assign dcross    = pcross_r - prod;
  assign div_start = (state_r == S_DSTART);

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    mrow_nxt    = mrow_r;
    lane_nxt    = lane_r;
    acc_nxt     = acc_r;
    wz_nxt      = wz_r;
    drow_nxt    = drow_r;
    held_wz_nxt = held_wz_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mrow_nxt  = 2'd3;
          lane_nxt  = 2'd0;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        acc_nxt = acc_sum;
        if (lane_r == 2'd3) begin
          // Row finished. Rows run w first, then x, y, z.
          acc_nxt  = '0;
          lane_nxt = 2'd0;
          if (mrow_r == 2'd2) begin
            drow_nxt  = 2'd0;
            state_nxt = wz_r ? S_STORE : S_DSTART;
          end else begin
            mrow_nxt  = (mrow_r == 2'd3) ? 2'd0 : mrow_r + 2'd1;
            state_nxt = S_MUL;
          end
          if (mrow_r == 2'd3) wz_nxt = (acc_sum[vtc_pkg::ACC_W-1:vtc_pkg::FRAC_SH] == '0);
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          if (drow_r == 2'd2) begin
            state_nxt = S_STORE;
          end else begin
            drow_nxt  = drow_r + 2'd1;
            state_nxt = S_DSTART;
          end
        end
      end
      S_STORE: begin
        if (count_r[1] == 1'b0) begin
          held_wz_nxt = (count_r == 2'd0) ? wz_r : (held_wz_r | wz_r);
          count_nxt   = count_r + 2'd1;
          state_nxt   = S_IDLE;
        end else begin
          count_nxt   = 2'd0;
          held_wz_nxt = 1'b0;
          state_nxt   = (held_wz_r | wz_r) ? S_IDLE : S_CUL1;
        end
      end
      S_CUL1: state_nxt = S_CUL2;
      S_CUL2: state_nxt = S_CUL3;
      S_CUL3: begin
        // A strictly positive cross product marks a back face.
        idx_nxt = 2'd0;
        if (!dcross[vtc_pkg::PROD_W-1] && (dcross != '0)) state_nxt = S_IDLE;
        else state_nxt = S_VPX;
      end
      S_VPX: state_nxt = S_VPY;
      S_VPY: state_nxt = S_VPO;
      S_VPO: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          if (idx_r == 2'd2) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = S_VPX;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_wz_r <= 1'b0;
      count_r   <= 2'd0;
      row_r[0]  <= vtc_pkg::ROW0_RST;
      row_r[1]  <= vtc_pkg::ROW1_RST;
      row_r[2]  <= vtc_pkg::ROW2_RST;
      row_r[3]  <= vtc_pkg::ROW3_RST;
      half_w_r  <= '0;
      half_h_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      held_wz_r <= held_wz_nxt;
      count_r   <= count_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          vtc_pkg::CFG_ROW0:   row_r[0] <= cfg_wdata;
          vtc_pkg::CFG_ROW1:   row_r[1] <= cfg_wdata;
          vtc_pkg::CFG_ROW2:   row_r[2] <= cfg_wdata;
          vtc_pkg::CFG_ROW3:   row_r[3] <= cfg_wdata;
          vtc_pkg::CFG_HALF_W: half_w_r <= cfg_wdata[CW-1:0];
          vtc_pkg::CFG_HALF_H: half_h_r <= cfg_wdata[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mrow_r <= mrow_nxt;
    lane_r <= lane_nxt;
    acc_r  <= acc_nxt;
    wz_r   <= wz_nxt;
    drow_r <= drow_nxt;
    idx_r  <= idx_nxt;
    if (state_r == S_IDLE && in_valid) begin
      vx_r <= in_vert_x;
      vy_r <= in_vert_y;
      vz_r <= in_vert_z;
      vu_r <= in_tex_u;
      vv_r <= in_tex_v;
    end
    if (state_r == S_ACC && lane_r == 2'd3) begin
      if (mrow_r == 2'd3) begin
        w_r <= acc_sum[vtc_pkg::ACC_W-1:vtc_pkg::FRAC_SH];
      end else begin
        clip_r[mrow_r] <= acc_sum[vtc_pkg::ACC_W-1:vtc_pkg::FRAC_SH];
      end
      // Zero w gives zero coordinates for this corner.
      if (mrow_r == 2'd2 && wz_r) begin
        ndc_r[0] <= '0;
        ndc_r[1] <= '0;
        ndc_r[2] <= '0;
      end
    end
    if (state_r == S_DWAIT && div_done) ndc_r[drow_r] <= div_quo;
    if (state_r == S_STORE && count_r[1] == 1'b0) begin
      held_x_r[count_r[0]] <= ndc_r[0];
      held_y_r[count_r[0]] <= ndc_r[1];
      held_z_r[count_r[0]] <= ndc_r[2];
      held_u_r[count_r[0]] <= vu_r;
      held_v_r[count_r[0]] <= vv_r;
    end
    if (state_r == S_CUL2) pcross_r <= prod;
    if (state_r == S_VPY) out_screen_x <= vp_res;
    if (state_r == S_VPO) begin
      out_screen_y         <= vp_res;
      out_ndc_depth        <= cz;
      out_out_u            <= cu;
      out_out_v            <= cv;
      out_corner           <= idx_r;
      out_last_of_triangle <= (idx_r == 2'd2);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  `VTC_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state_r == S_MUL, "accept lost")
  `VTC_ASSERT_IMP(a_emit_after_triangle, out_valid, count_r == 2'd0 && !held_wz_r, "early item")
  `VTC_ASSERT_IMP(a_div_done_waited, div_done, state_r == S_DWAIT, "divider done outside wait")
  `VTC_ASSERT_IMP(a_last_third, out_valid && out_last_of_triangle, out_corner == 2'd2, "bad last")

endmodule

`default_nettype wire

// ----- tb/vertex_transform_cull_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vertex transform and cull testbench
// Feeds triangles through the block under several matrix and viewport
// settings. A behavioral model of the transform, divide, cull and viewport
// mapping predicts every screen vertex, and each result item is checked
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_transform_cull_tb;

  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  HOLD_CYCLES    = 2000;
  localparam int  SETTLE_CYCLES  = 400;
  localparam int  PHASE_ITEMS    = 72;
  localparam int  RANDOM_PHASES  = 6;

  // Idling patterns: sender then receiver percentages.
  typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] depth;
    logic [15:0]        u;
    logic [15:0]        v;
    logic [1:0]         corner;
    logic               last;
  } screen_vertex_t;

  typedef struct {
    int          phase;
    logic [31:0] x, y, z;
    logic [15:0] u, v;
    bit          typed;
    logic [31:0] tdepth;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [vtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vtc_pkg::ROW_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [vtc_pkg::COORD_W-1:0] in_vert_x = '0, in_vert_y = '0, in_vert_z = '0;
  logic [vtc_pkg::TEX_W-1:0] in_tex_u = '0, in_tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [vtc_pkg::COORD_W-1:0] out_screen_x, out_screen_y, out_ndc_depth;
  logic [vtc_pkg::TEX_W-1:0] out_out_u, out_out_v;
  logic [1:0] out_corner;
  logic out_last_of_triangle;

  vertex_transform_cull dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block's configuration and triangle state.
  logic [63:0] mvp [4];
  logic [31:0] half_w, half_h;
  logic signed [31:0] held_x [2], held_y [2], held_z [2];
  logic [15:0] held_u [2], held_v [2];
  bit held_w_zero;
  int corner_cnt;

  screen_vertex_t screen_q[$];
  int errors = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint lane_coef(int r, int j);
    logic signed [15:0] c;
    c = mvp[r][16*j +: 16];
    return longint'(c);
  endfunction

  // Clip component: exact sum with 28 fraction bits, floored to Q16.16.
  function automatic longint clip_of(int r, longint x, longint y, longint z);
    longint s;
    s = lane_coef(r, 0) * x + lane_coef(r, 1) * y + lane_coef(r, 2) * z
      + lane_coef(r, 3) * 64'sd65536;
    return s >>> 12;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] to_screen(logic signed [31:0] ndc,
                                                   logic [31:0] half);
    longint s;
    longint r;
    logic [127:0] m;
    s = longint'(ndc) + 64'sd65536;
    m = (s < 0) ? 128'(-s) : 128'(s);
    m = (m * {96'd0, half}) >> 16;
    r = longint'(m[63:0]);
    return clamp32((s < 0) ? -r : r);
  endfunction

  // Positive z of cross(p1 - p0, p2 - p1) marks a back face.
  function automatic bit back_facing(logic signed [31:0] px [3],
                                     logic signed [31:0] py [3]);
    logic signed [127:0] ax, ay, bx, by, d;
    ax = longint'(px[1]) - longint'(px[0]);
    ay = longint'(py[1]) - longint'(py[0]);
    bx = longint'(px[2]) - longint'(px[1]);
    by = longint'(py[2]) - longint'(py[1]);
    d = ax * by - ay * bx;
    return d > 0;
  endfunction

  task automatic predict_vertex(logic signed [31:0] vx, logic signed [31:0] vy,
                                logic signed [31:0] vz, logic [15:0] u,
                                logic [15:0] v);
    longint x, y, z, w;
    logic signed [31:0] nx, ny, nz;
    logic signed [31:0] px [3], py [3], pz [3];
    logic [15:0] pu [3], pv [3];
    bit wz;
    screen_vertex_t e;
    x = vx; y = vy; z = vz;
    w = clip_of(3, x, y, z);
    wz = (w == 0);
    nx = 0; ny = 0; nz = 0;
    if (!wz) begin
      nx = clamp32((clip_of(0, x, y, z) * 64'sd65536) / w);
      ny = clamp32((clip_of(1, x, y, z) * 64'sd65536) / w);
      nz = clamp32((clip_of(2, x, y, z) * 64'sd65536) / w);
    end
    if (corner_cnt < 2) begin
      held_x[corner_cnt] = nx;
      held_y[corner_cnt] = ny;
      held_z[corner_cnt] = nz;
      held_u[corner_cnt] = u;
      held_v[corner_cnt] = v;
      held_w_zero = (corner_cnt == 0) ? wz : (held_w_zero || wz);
      corner_cnt++;
      return;
    end
    corner_cnt = 0;
    if (held_w_zero || wz) begin
      held_w_zero = 0;
      return;
    end
    for (int k = 0; k < 2; k++) begin
      px[k] = held_x[k]; py[k] = held_y[k]; pz[k] = held_z[k];
      pu[k] = held_u[k]; pv[k] = held_v[k];
    end
    px[2] = nx; py[2] = ny; pz[2] = nz; pu[2] = u; pv[2] = v;
    if (back_facing(px, py)) return;
    for (int k = 0; k < 3; k++) begin
      e.sx = to_screen(px[k], half_w);
      e.sy = to_screen(py[k], half_h);
      e.depth = pz[k];
      e.u = pu[k];
      e.v = pv[k];
      e.corner = 2'(k);
      e.last = (k == 2);
      screen_q.insert(screen_q.size(), e);
    end
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // Writes all six registers back to back; the shadow follows.
  task automatic load_config(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                             logic [63:0] r3, logic [31:0] hw, logic [31:0] hh);
    logic [63:0] vals [6];
    vals = '{r0, r1, r2, r3, {32'd0, hw}, {32'd0, hh}};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= vtc_pkg::CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    mvp[0] = r0;
    mvp[1] = r1;
    mvp[2] = r2;
    mvp[3] = r3;
    half_w = hw;
    half_h = hh;
  endtask

  // Dropped triangles leave the block busy with no result to wait on, so
  // the settle time covers one full vertex after the queue drains.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called at an edge where the previous item was accepted (or the port
  // is idle); returns at the edge where this item is accepted.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] u, logic [15:0] v);
    int pct;
    pct = (idle_mode == IDLE_SEND_LIGHT) ? 19 : (idle_mode == IDLE_SEND_HEAVY) ? 83 : 0;
    if ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vert_x <= x;
    in_vert_y <= y;
    in_vert_z <= z;
    in_tex_u <= u;
    in_tex_v <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertex(x, y, z, u, v);
  endtask

  function automatic logic [15:0] small_coef(int span);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [31:0] rand_coord(bit zero_ok);
    int pick;
    pick = $urandom_range(99);
    if (zero_ok && pick < 5) return 32'd0;
    if (pick < 85) return 32'($signed($urandom_range(32'h60000)) - 32'sh30000);
    return $urandom;
  endfunction

  // Receiver: checks result items and chooses its stall for the next cycle.
  always @(posedge clk) begin
    screen_vertex_t e;
    int pct;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (screen_q.size() == 0) begin
          report("unexpected item", out_corner, 0);
        end else begin
          e = screen_q.pop_front();
          if (out_screen_x !== e.sx) report("screen_x", out_screen_x, e.sx);
          if (out_screen_y !== e.sy) report("screen_y", out_screen_y, e.sy);
          if (out_ndc_depth !== e.depth) report("ndc_depth", out_ndc_depth, e.depth);
          if (out_out_u !== e.u) report("out_u", out_out_u, e.u);
          if (out_out_v !== e.v) report("out_v", out_out_v, e.v);
          if (out_corner !== e.corner) report("corner", out_corner, e.corner);
          if (out_last_of_triangle !== e.last)
            report("last_of_triangle", out_last_of_triangle, e.last);
        end
      end
      pct = (idle_mode == IDLE_SEND_LIGHT) ? 83 : (idle_mode == IDLE_SEND_HEAVY) ? 19 : 0;
      if (hold_ask != hold_seen) begin
        hold_seen <= hold_ask;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed items. Phase 0 runs on reset settings: identity matrix, zero
  // viewport scale, so screen x, y are zero and depth equals input z.
  dir_row_t dir_tbl [24] = '{
    '{0, 32'h0000_0000, 32'h0000_0000, 32'h0001_2345, 16'h0000, 16'hFFFF, 1, 32'h0001_2345},
    '{0, 32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 16'hFFFF, 16'h0000, 1, 32'h8000_0000},
    '{0, 32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF, 16'h1234, 16'hABCD, 1, 32'h7FFF_FFFF},
    // Corners at the coordinate extremes.
    '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 0, 32'h0},
    '{0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 0, 32'h0},
    '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h5555, 16'hAAAA, 0, 32'h0},
    // Clockwise winding: dropped as a back face.
    '{0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h0001, 16'h0002, 0, 32'h0},
    '{0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 16'h0003, 16'h0004, 0, 32'h0},
    '{0, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 16'h0005, 16'h0006, 0, 32'h0},
    // Phase 1: w equals z. Zero w on the second corner, then on the third.
    '{1, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 16'h1111, 16'h2222, 0, 32'h0},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h3333, 16'h4444, 0, 32'h0},
    '{1, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 16'h5555, 16'h6666, 0, 32'h0},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 16'h1111, 16'h2222, 0, 32'h0},
    '{1, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 16'h3333, 16'h4444, 0, 32'h0},
    '{1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 16'h5555, 16'h6666, 0, 32'h0},
    // Tiny w: the divide saturates both ways.
    '{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'h0F0F, 16'hF0F0, 0, 32'h0},
    '{1, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 16'h00FF, 16'hFF00, 0, 32'h0},
    '{1, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 16'h7FFF, 16'h8000, 0, 32'h0},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 16'h0000, 16'h0000, 0, 32'h0},
    '{1, 32'h0000_8000, 32'h0000_8000, 32'h0002_0000, 16'h0000, 16'h0000, 0, 32'h0},
    '{1, 32'hFFFF_0000, 32'h0000_4000, 32'h0000_8000, 16'h0000, 16'h0000, 0, 32'h0},
    // Phase 2: extreme, small and zero coefficients across the lanes.
    '{2, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 16'h9999, 16'h6666, 0, 32'h0},
    '{2, 32'hFFFF_F000, 32'h0000_0100, 32'h0000_0010, 16'h8888, 16'h7777, 0, 32'h0},
    '{2, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 16'h4444, 16'hBBBB, 0, 32'h0}
  };

  initial begin
    int phase;
    int typed_run;
    int n;
    logic [63:0] r [4];
    logic [31:0] hw, hh;
    mvp[0] = vtc_pkg::ROW0_RST;
    mvp[1] = vtc_pkg::ROW1_RST;
    mvp[2] = vtc_pkg::ROW2_RST;
    mvp[3] = vtc_pkg::ROW3_RST;
    half_w = 0;
    half_h = 0;
    held_w_zero = 0;
    corner_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    phase = 0;
    typed_run = 0;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].phase != phase) begin
        wait_idle();
        phase = dir_tbl[i].phase;
        if (phase == 1)
          load_config(vtc_pkg::ROW0_RST, vtc_pkg::ROW1_RST, vtc_pkg::ROW2_RST,
                      64'h0000_1000_0000_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        else
          load_config(64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_FFFF_0001,
                      64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_0001_0000_8000,
                      32'h0000_0000, 32'hFFFF_FFFF);
      end
      send_vertex(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z, dir_tbl[i].u, dir_tbl[i].v);
      // Typed triangles replace the predicted values with the ones read
      // off the reset settings directly.
      typed_run = dir_tbl[i].typed ? typed_run + 1 : 0;
      if (typed_run == 3) begin
        n = screen_q.size();
        for (int k = 0; k < 3; k++) begin
          screen_q[n - 3 + k].sx = 0;
          screen_q[n - 3 + k].sy = 0;
          screen_q[n - 3 + k].depth = dir_tbl[i - 2 + k].tdepth;
        end
        typed_run = 0;
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      idle_mode = (p < 2) ? IDLE_SEND_LIGHT : (p < 4) ? IDLE_SEND_HEAVY : IDLE_NONE;
      for (int row = 0; row < 3; row++)
        r[row] = {small_coef(16'h1000), small_coef(16'h2000),
                  small_coef(16'h2000), small_coef(16'h2000)};
      r[3] = {16'(16'h0800 + $urandom_range(16'h1000)), small_coef(16'h0400),
              small_coef(16'h0400), small_coef(16'h0400)};
      // One setting makes w depend on z alone so zero w shows up often.
      if (p == 3) r[3] = {16'h0000, small_coef(16'h2000), 16'h0000, 16'h0000};
      if (p == 5) r = '{{$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}};
      hw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000);
      hh = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0400_0000);
      load_config(r[0], r[1], r[2], r[3], hw, hh);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // A long receiver hold while the sender keeps offering items.
        if (p == 4 && i == 10) hold_ask++;
        send_vertex(rand_coord(0), rand_coord(0), rand_coord(p == 3),
                    16'($urandom), 16'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- vertex_transform_cull.f -----
+incdir+rtl
rtl/vtc_pkg.sv
rtl/vtc_mul.sv
rtl/vtc_div.sv
rtl/vertex_transform_cull.sv
tb/vertex_transform_cull_tb.sv
